// ===== src/pgac_pkg.sv =====
package pgac_pkg;

  localparam int PRESENCE_W = 4;
  localparam int GAS_W      = 10;
  localparam int DEBOUNCE_W = 8;
  localparam int DIVIDE_W   = 7;
  localparam int ELAPSED_W  = 11;
  localparam int MSG_W      = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_GAS_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIVIDE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND_TICKS   = 2'd3;

  // register reset values
  localparam logic [GAS_W-1:0]      GAS_THRESHOLD_RST  = 10'd200;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST = 8'd20;
  localparam logic [DIVIDE_W-1:0]   SLOW_DIVIDE_RST    = 7'd100;
  localparam logic [ELAPSED_W-1:0]  RESEND_TICKS_RST   = 11'd1200;

  // message codes
  localparam logic [MSG_W-1:0] MSG_NONE    = 2'd0;
  localparam logic [MSG_W-1:0] MSG_STARTED = 2'd1;
  localparam logic [MSG_W-1:0] MSG_ALARM   = 2'd2;

  typedef struct packed {
    logic [PRESENCE_W-1:0] presence_bits;
    logic                  button_level;
    logic [GAS_W-1:0]      gas_sample;
  } in_word_t;

  typedef struct packed {
    logic             lamp_on;
    logic             siren_relay_on;
    logic [MSG_W-1:0] message_request;
    logic             alarm_active;
  } out_word_t;

  typedef struct packed {
    logic [GAS_W-1:0]      gas_threshold;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [DIVIDE_W-1:0]   slow_tick_divide;
    logic [ELAPSED_W-1:0]  resend_slow_ticks;
  } cfg_t;

endpackage

// ===== src/pgac_in_if.sv =====
interface pgac_in_if import pgac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRESENCE_W-1:0] presence_bits;
  logic                  button_level;
  logic [GAS_W-1:0]      gas_sample;

  modport source (output valid, output presence_bits, output button_level,
                  output gas_sample, input ready);
  modport sink (input valid, input presence_bits, input button_level,
                input gas_sample, output ready);
endinterface

// ===== src/pgac_out_if.sv =====
interface pgac_out_if import pgac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             lamp_on;
  logic             siren_relay_on;
  logic [MSG_W-1:0] message_request;
  logic             alarm_active;

  modport source (output valid, output lamp_on, output siren_relay_on,
                  output message_request, output alarm_active, input ready);
  modport sink (input valid, input lamp_on, input siren_relay_on,
                input message_request, input alarm_active, output ready);
endinterface

// ===== src/pgac_cfg.sv =====
module pgac_cfg import pgac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gas_threshold     <= GAS_THRESHOLD_RST;
      cfg.debounce_ticks    <= DEBOUNCE_TICKS_RST;
      cfg.slow_tick_divide  <= SLOW_DIVIDE_RST;
      cfg.resend_slow_ticks <= RESEND_TICKS_RST;
    end else if (we) begin
      unique case (index)
        REG_GAS_THRESHOLD:  cfg.gas_threshold     <= data[GAS_W-1:0];
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks    <= data[DEBOUNCE_W-1:0];
        REG_SLOW_DIVIDE:    cfg.slow_tick_divide  <= data[DIVIDE_W-1:0];
        REG_RESEND_TICKS:   cfg.resend_slow_ticks <= data[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pgac_core.sv =====
module pgac_core import pgac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      advance,
  input  in_word_t  item,
  output out_word_t result
);

  localparam logic [MODE_W-1:0] MODE_STARTUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WATCH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALARM   = 2'd2;

  logic [MODE_W-1:0]     mode, mode_next;
  logic [DIVIDE_W-1:0]   slow_divider, slow_divider_next;
  logic [DEBOUNCE_W-1:0] debounce_count, debounce_count_next;
  logic                  button_last, button_last_next;
  logic                  button_stable, button_stable_next;
  logic                  message_sent, message_sent_next;
  logic [ELAPSED_W-1:0]  alarm_elapsed, alarm_elapsed_next;

  logic [DEBOUNCE_W-1:0] count_mid;
  logic [DIVIDE_W-1:0]   div_inc;
  logic [ELAPSED_W-1:0]  elapsed_inc;
  logic                  slow_tick;
  logic                  pressed;
  logic [MSG_W-1:0]      msg;
  logic                  on;

  always_comb begin
    // debounce: a change reloads, a steady level with the count run out is taken
    button_last_next   = button_last;
    button_stable_next = button_stable;
    count_mid          = debounce_count;
    if (item.button_level != button_last) begin
      button_last_next = item.button_level;
      count_mid        = cfg.debounce_ticks;
    end else if (debounce_count == '0) begin
      button_stable_next = button_last;
    end
    debounce_count_next = (count_mid != '0) ? count_mid - 1'b1 : count_mid;

    // slow tick divider, fires and clears when the incremented count reaches the divide value
    div_inc           = slow_divider + 1'b1;
    slow_tick         = (div_inc >= cfg.slow_tick_divide);
    slow_divider_next = slow_tick ? '0 : div_inc;

    pressed = !button_stable_next;

    mode_next          = mode;
    message_sent_next  = message_sent;
    alarm_elapsed_next = alarm_elapsed;
    msg                = MSG_NONE;
    elapsed_inc        = (alarm_elapsed != '1) ? alarm_elapsed + 1'b1 : alarm_elapsed;

    unique case (mode)
      MODE_STARTUP: begin
        msg                = MSG_STARTED;
        message_sent_next  = 1'b0;
        alarm_elapsed_next = '0;
        mode_next          = MODE_WATCH;
      end
      MODE_ALARM: begin
        if (slow_tick) begin
          if (!message_sent) begin
            msg               = MSG_ALARM;
            message_sent_next = 1'b1;
          end
          alarm_elapsed_next = elapsed_inc;
          if (elapsed_inc >= cfg.resend_slow_ticks && !pressed) begin
            msg                = MSG_ALARM;
            alarm_elapsed_next = '0;
          end
        end
        if (pressed) begin
          message_sent_next = 1'b0;
          mode_next         = MODE_WATCH;
        end
      end
      default: begin
        // watch, and the unused code behaves as watch
        mode_next = MODE_WATCH;
        if (slow_tick && item.presence_bits != '0 &&
            item.gas_sample > cfg.gas_threshold) begin
          mode_next          = MODE_ALARM;
          alarm_elapsed_next = '0;
          message_sent_next  = 1'b0;
        end
      end
    endcase

    on                     = (mode_next == MODE_ALARM);
    result.lamp_on         = on;
    result.siren_relay_on  = on;
    result.message_request = msg;
    result.alarm_active    = on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_STARTUP;
      slow_divider   <= '0;
      debounce_count <= '0;
      button_last    <= 1'b1;
      button_stable  <= 1'b1;
      message_sent   <= 1'b0;
      alarm_elapsed  <= '0;
    end else if (advance) begin
      mode           <= mode_next;
      slow_divider   <= slow_divider_next;
      debounce_count <= debounce_count_next;
      button_last    <= button_last_next;
      button_stable  <= button_stable_next;
      message_sent   <= message_sent_next;
      alarm_elapsed  <= alarm_elapsed_next;
    end
  end

endmodule

// ===== src/presence_gas_alarm_controller_unit.sv =====
// channel  | dir | handshake     | word
// ---------+-----+---------------+-------------------------------------------------
// sensor   | in  | valid / ready | presence_bits[3:0], button_level, gas_sample[9:0]
// alarm    | out | valid / ready | lamp_on, siren_relay_on, message_request[1:0],
//          |     |               | alarm_active
// cfg      | in  | cfg_we        | cfg_index[1:0], cfg_data[10:0]
//
// One word per clock sustained while the alarm side is ready; a word passes the
// input register, then the result register. All controller state advances when
// a word moves from the input register into the result register.
// rst is synchronous, active high; config returns to its defaults.
// Stalls: a full result register holds until taken; the input register still
// takes a word while the result register drains in the same cycle.
module presence_gas_alarm_controller_unit import pgac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pgac_in_if.sink               sensor,
  pgac_out_if.source            alarm,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  in_word_t  s1_word;
  logic      out_valid;
  out_word_t out_word;
  out_word_t result;
  logic      out_free;
  logic      advance;

  // result register can take a word when empty or being drained
  assign out_free     = !out_valid || alarm.ready;
  assign advance      = s1_valid && out_free;
  assign sensor.ready = !s1_valid || out_free;

  pgac_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sensor.ready) begin
      s1_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      s1_word.presence_bits <= sensor.presence_bits;
      s1_word.button_level  <= sensor.button_level;
      s1_word.gas_sample    <= sensor.gas_sample;
    end
  end

  pgac_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (s1_word),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign alarm.valid           = out_valid;
  assign alarm.lamp_on         = out_word.lamp_on;
  assign alarm.siren_relay_on  = out_word.siren_relay_on;
  assign alarm.message_request = out_word.message_request;
  assign alarm.alarm_active    = out_word.alarm_active;

endmodule
